// ===== hdl/assert_macros.svh =====
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define SPMA_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication, off while reset is high.
`define SPMA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication that also holds across reset.
`define SPMA_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

// ===== hdl/spma_pkg.sv =====
// Types and constants of the sensor percent moving average block.
package spma_pkg;

  localparam int FULL_SCALE   = 25600;  // 100 percent in 1/256 percent
  localparam int LEVEL_W      = 15;
  localparam int FUNC_W       = 2;
  localparam int RAW_W        = 13;
  localparam int CODE_W       = 12;
  localparam int HEIGHT_W     = 10;
  localparam int CFG_DATA_W   = 12;
  localparam int CFG_INDEX_W  = 3;
  localparam int QUEUE_DEPTH  = 2;

  // percent divider: numerator up to 4095*25600, divisor is a 12-bit span
  localparam int PCT_NUM_W    = 27;
  localparam int PCT_DEN_W    = 12;

  // channel codes
  localparam logic [FUNC_W-1:0] CH_SOIL  = 2'd0;
  localparam logic [FUNC_W-1:0] CH_LIGHT = 2'd1;
  localparam logic [FUNC_W-1:0] CH_WATER = 2'd2;

  // register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_LIGHT_MIN     = 3'd0,
    CFG_LIGHT_MAX     = 3'd1,
    CFG_SOIL_MIN      = 3'd2,
    CFG_SOIL_MAX      = 3'd3,
    CFG_SENSOR_HEIGHT = 3'd4,
    CFG_FULL_HEIGHT   = 3'd5
  } cfg_index_t;

  localparam logic [CODE_W-1:0]   RST_LIGHT_MIN     = 12'd300;
  localparam logic [CODE_W-1:0]   RST_LIGHT_MAX     = 12'd3600;
  localparam logic [CODE_W-1:0]   RST_SOIL_MIN      = 12'd150;
  localparam logic [CODE_W-1:0]   RST_SOIL_MAX      = 12'd3600;
  localparam logic [HEIGHT_W-1:0] RST_SENSOR_HEIGHT = 10'd200;
  localparam logic [HEIGHT_W-1:0] RST_FULL_HEIGHT   = 10'd180;

  typedef struct packed {
    logic [CODE_W-1:0]   light_min_code;
    logic [CODE_W-1:0]   light_max_code;
    logic [CODE_W-1:0]   soil_min_code;
    logic [CODE_W-1:0]   soil_max_code;
    logic [HEIGHT_W-1:0] sensor_height_mm;
    logic [HEIGHT_W-1:0] full_height_mm;
  } cfg_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [RAW_W-1:0]  raw_sample;
  } sample_t;

  typedef struct packed {
    logic [FUNC_W-1:0]  channel;
    logic [LEVEL_W-1:0] level;
    logic               level_valid;
  } result_t;

  // converted sample handed from front to back
  typedef struct packed {
    logic [FUNC_W-1:0]  channel;
    logic [LEVEL_W-1:0] value;
    logic               ok;
  } slot_item_t;

  // one ring slot as stored in memory
  typedef struct packed {
    logic [LEVEL_W-1:0] value;
    logic               ok;
  } slot_word_t;

  typedef enum logic [2:0] {
    FR_IDLE,
    FR_PREP,
    FR_DIV,
    FR_WAIT,
    FR_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_LOAD,
    BK_UPDATE,
    BK_DIV,
    BK_WAIT,
    BK_EMIT
  } back_state_t;

endpackage

// ===== hdl/spma_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module spma_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 24,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/spma_div.sv =====
// Restoring divider, one quotient bit per cycle; needs dividend < divisor << QUO_W.
module spma_div #(
  parameter int NUM_W = 27,
  parameter int DEN_W = 12,
  parameter int QUO_W = 15
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             done,
  output logic [QUO_W-1:0] quotient
);

  localparam int CNT_W = $clog2(QUO_W + 1);

  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den;
  logic [QUO_W-1:0] quo;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             fits;

  assign trial    = {rem, quo[QUO_W-1]};
  assign fits     = trial >= {1'b0, den};
  assign diff     = trial - {1'b0, den};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CNT_W'(QUO_W);
      end else if (cnt != '0) begin
        cnt  <= cnt - 1'b1;
        done <= (cnt == CNT_W'(1));
      end
    end
  end

  // low bits of the dividend shift out as quotient bits shift in
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= DEN_W'(dividend >> QUO_W);
      quo <= dividend[QUO_W-1:0];
      den <= divisor;
    end else if (cnt != '0) begin
      rem <= fits ? DEN_W'(diff) : DEN_W'(trial);
      quo <= {quo[QUO_W-2:0], fits};
    end
  end

endmodule

// ===== hdl/spma_queue.sv =====
// Small FIFO of converted samples between front and back.
module spma_queue import spma_pkg::*; #(
  parameter int DEPTH = 2,
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  slot_item_t wr_item,
  output logic       full,
  input  logic       pop,
  output slot_item_t rd_item,
  output logic       empty
);

  slot_item_t       entries [DEPTH];
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W-1:0] wr_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_item = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wr_item;
    end
  end

endmodule

// ===== hdl/spma_front.sv =====
// Front end: takes a raw sample, checks it and converts it to percent.
module spma_front import spma_pkg::*; #(
  parameter int CHANNEL_COUNT = 3
) (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       push,
  output logic       full,
  input  sample_t    sample,
  output logic       q_push,
  output slot_item_t q_item,
  input  logic       q_full
);

  front_state_t state, state_next;

  logic [FUNC_W-1:0]    func_q;
  logic [RAW_W-1:0]     raw_q;
  logic                 ok_q;
  logic [PCT_NUM_W-1:0] num_q;
  logic [PCT_DEN_W-1:0] den_q;
  logic                 invert_q;
  logic [LEVEL_W-1:0]   val_q;

  logic                 in_range;
  logic                 div_start;
  logic                 div_done;
  logic [LEVEL_W-1:0]   div_q;

  // conversion setup
  logic [CODE_W-1:0]    lo;
  logic [CODE_W-1:0]    hi;
  logic signed [13:0]   adc_num;
  logic signed [12:0]   adc_den;
  logic [12:0]          adc_an;
  logic [11:0]          adc_ad;
  logic [18:0]          w_num;
  logic [16:0]          full100;
  logic                 w_pos;
  logic                 prep_direct;
  logic [LEVEL_W-1:0]   prep_val;
  logic [PCT_NUM_W-1:0] prep_num;
  logic [PCT_DEN_W-1:0] prep_den;
  logic                 prep_invert;

  assign in_range = (int'(sample.func) < CHANNEL_COUNT);

  always_comb begin
    lo          = (func_q == CH_SOIL) ? cfg.soil_min_code : cfg.light_min_code;
    hi          = (func_q == CH_SOIL) ? cfg.soil_max_code : cfg.light_max_code;
    adc_num     = $signed({1'b0, raw_q}) - $signed({2'b00, lo});
    adc_den     = $signed({1'b0, hi}) - $signed({1'b0, lo});
    adc_an      = adc_num[13] ? 13'(-adc_num) : adc_num[12:0];
    adc_ad      = adc_den[12] ? 12'(-adc_den) : adc_den[11:0];
    // echo * 0.17 mm, scaled by 100 to stay integer
    w_num       = 19'(cfg.sensor_height_mm) * 19'd100 - 19'(raw_q) * 19'd17;
    full100     = 17'(cfg.full_height_mm) * 17'd100;
    w_pos       = !w_num[18] && (w_num != '0);
    prep_direct = 1'b1;
    prep_val    = '0;
    prep_num    = '0;
    prep_den    = '0;
    prep_invert = 1'b0;
    if (raw_q != '0) begin
      case (func_q) inside
        CH_SOIL, CH_LIGHT: begin
          if (adc_den == '0) begin
            prep_val = (!adc_num[13] && adc_num != '0) ? '0 : LEVEL_W'(FULL_SCALE);
          end else if ((adc_num[13] != adc_den[12]) || (adc_num == '0)) begin
            prep_val = LEVEL_W'(FULL_SCALE);
          end else if (adc_an >= 13'(adc_ad)) begin
            prep_val = '0;
          end else begin
            prep_direct = 1'b0;
            prep_num    = PCT_NUM_W'(adc_an[11:0]) * PCT_NUM_W'(FULL_SCALE);
            prep_den    = adc_ad;
            prep_invert = 1'b1;
          end
        end
        default: begin
          if (!w_pos) begin
            prep_val = '0;
          end else if (cfg.full_height_mm == '0) begin
            prep_val = LEVEL_W'(FULL_SCALE);
          end else if (w_num[17:0] >= 18'(full100)) begin
            prep_val = LEVEL_W'(FULL_SCALE);
          end else begin
            prep_direct = 1'b0;
            prep_num    = {2'b00, w_num[16:0], 8'h00};
            prep_den    = PCT_DEN_W'(cfg.full_height_mm);
          end
        end
      endcase
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      FR_IDLE: if (push && in_range) state_next = FR_PREP;
      FR_PREP: state_next = prep_direct ? FR_PUSH : FR_DIV;
      FR_DIV:  state_next = FR_WAIT;
      FR_WAIT: if (div_done) state_next = FR_PUSH;
      FR_PUSH: if (!q_full) state_next = FR_IDLE;
      default: state_next = FR_IDLE;
    endcase
  end

  always_comb begin
    full      = (state != FR_IDLE);
    div_start = (state == FR_DIV);
    q_push    = (state == FR_PUSH) && !q_full;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FR_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == FR_IDLE && push) begin
      func_q <= sample.func;
      raw_q  <= sample.raw_sample;
      ok_q   <= (sample.raw_sample != '0);
    end
    if (state == FR_PREP) begin
      num_q    <= prep_num;
      den_q    <= prep_den;
      invert_q <= prep_invert;
      val_q    <= prep_val;
    end
    if (state == FR_WAIT && div_done) begin
      val_q <= invert_q ? LEVEL_W'(FULL_SCALE) - div_q : div_q;
    end
  end

  assign q_item = '{channel: func_q, value: val_q, ok: ok_q};

  spma_div #(
    .NUM_W (PCT_NUM_W),
    .DEN_W (PCT_DEN_W),
    .QUO_W (LEVEL_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (num_q),
    .divisor  (den_q),
    .done     (div_done),
    .quotient (div_q)
  );

endmodule

// ===== hdl/spma_back.sv =====
// Back end: per-channel ring update, running sum and rounded window mean.
module spma_back import spma_pkg::*; #(
  parameter int WINDOW_DEPTH  = 8,
  parameter int CHANNEL_COUNT = 3
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_empty,
  output logic       q_pop,
  input  slot_item_t q_item,
  output logic       empty,
  input  logic       pop,
  output result_t    result
);

  localparam int CH_W      = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
  localparam int SLOT_W    = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int FILL_W    = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W     = LEVEL_W + FILL_W;
  localparam int MEM_DEPTH = CHANNEL_COUNT * WINDOW_DEPTH;
  localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int WORD_W    = $bits(slot_word_t);

  back_state_t state, state_next;

  logic [SLOT_W-1:0] wr_slot   [CHANNEL_COUNT];
  logic [FILL_W-1:0] fill      [CHANNEL_COUNT];
  logic [SUM_W-1:0]  sum       [CHANNEL_COUNT];
  logic [FILL_W-1:0] bad_count [CHANNEL_COUNT];

  slot_item_t        item_q;
  logic [CH_W-1:0]   ch_idx;
  logic [ADDR_W-1:0] addr;
  slot_word_t        rd_word;
  logic [WORD_W-1:0] rd_bits;
  logic              win_full;
  logic [LEVEL_W-1:0] old_val;
  logic              old_bad;
  logic              ram_we;

  logic              div_start;
  logic              div_done;
  logic [SUM_W:0]    div_num;
  logic [LEVEL_W-1:0] div_q;

  logic              res_valid;
  logic              res_load;

  assign ch_idx  = CH_W'(item_q.channel);
  assign addr    = ADDR_W'(int'(ch_idx) * WINDOW_DEPTH + int'(wr_slot[ch_idx]));
  assign rd_word = slot_word_t'(rd_bits);

  // before the ring wraps the slot under the write pointer was never written
  assign win_full = (fill[ch_idx] == FILL_W'(WINDOW_DEPTH));
  assign old_val  = win_full ? rd_word.value : '0;
  assign old_bad  = win_full && !rd_word.ok;
  assign div_num  = {1'b0, sum[ch_idx]} + (SUM_W + 1)'(fill[ch_idx] >> 1);

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE:   if (!q_empty) state_next = BK_LOAD;
      BK_LOAD:   state_next = BK_UPDATE;
      BK_UPDATE: state_next = BK_DIV;
      BK_DIV:    state_next = BK_WAIT;
      BK_WAIT:   if (div_done) state_next = BK_EMIT;
      BK_EMIT:   if (!res_valid || pop) state_next = BK_IDLE;
      default:   state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = (state == BK_IDLE) && !q_empty;
    ram_we    = (state == BK_UPDATE);
    div_start = (state == BK_DIV);
    res_load  = (state == BK_EMIT) && (!res_valid || pop);
    empty     = !res_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      res_valid <= 1'b0;
      for (int c = 0; c < CHANNEL_COUNT; c++) begin
        wr_slot[c]   <= '0;
        fill[c]      <= '0;
        sum[c]       <= '0;
        bad_count[c] <= '0;
      end
    end else begin
      state <= state_next;
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (pop) begin
        res_valid <= 1'b0;
      end
      if (state == BK_UPDATE) begin
        sum[ch_idx]       <= sum[ch_idx] - SUM_W'(old_val) + SUM_W'(item_q.value);
        bad_count[ch_idx] <= bad_count[ch_idx] - FILL_W'(old_bad) + FILL_W'(!item_q.ok);
        wr_slot[ch_idx]   <= (wr_slot[ch_idx] == SLOT_W'(WINDOW_DEPTH - 1))
                             ? '0 : wr_slot[ch_idx] + 1'b1;
        if (!win_full) begin
          fill[ch_idx] <= fill[ch_idx] + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      item_q <= q_item;
    end
    if (res_load) begin
      result.channel     <= item_q.channel;
      result.level       <= (bad_count[ch_idx] == '0) ? div_q : '0;
      result.level_valid <= (bad_count[ch_idx] == '0);
    end
  end

  spma_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MEM_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr),
    .wdata (WORD_W'(slot_word_t'{value: item_q.value, ok: item_q.ok})),
    .raddr (addr),
    .rdata (rd_bits)
  );

  spma_div #(
    .NUM_W (SUM_W + 1),
    .DEN_W (FILL_W),
    .QUO_W (LEVEL_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (fill[ch_idx]),
    .done     (div_done),
    .quotient (div_q)
  );

endmodule

// ===== hdl/sensor_percent_moving_average_top.sv =====
// Top level: sensor percent conversion with per-channel moving average.
// Pace: set by the 15-step divider in the back end; the front end has its own 15-step
// divider and skips it when no division is needed. The front end takes a new request
// only once its last one is pushed to the queue, and a result comes later while
// earlier requests still wait in the queue.
// Reset: synchronous, active high; registers return to their reset values at once and
// ring slots not yet written read as zero and valid, so no clearing pass is needed.
module sensor_percent_moving_average_top import spma_pkg::*; #(
  parameter int WINDOW_DEPTH  = 8,
  parameter int CHANNEL_COUNT = 3
) (
  input  logic                   clk,
  input  logic                   rst,
  // input request queue side
  input  logic                   push,
  output logic                   full,
  input  sample_t                sample,
  // result queue side
  output logic                   empty,
  input  logic                   pop,
  output result_t                result,
  // configuration write port
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t       cfg;
  logic       q_push;
  logic       q_pop;
  logic       q_full;
  logic       q_empty;
  slot_item_t q_wr_item;
  slot_item_t q_rd_item;

  // Configuration registers. Writes take effect at once and are meant to be
  // made only while no request is in flight; indexes past the last register
  // are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.light_min_code   <= RST_LIGHT_MIN;
      cfg.light_max_code   <= RST_LIGHT_MAX;
      cfg.soil_min_code    <= RST_SOIL_MIN;
      cfg.soil_max_code    <= RST_SOIL_MAX;
      cfg.sensor_height_mm <= RST_SENSOR_HEIGHT;
      cfg.full_height_mm   <= RST_FULL_HEIGHT;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_LIGHT_MIN:     cfg.light_min_code   <= cfg_data;
        CFG_LIGHT_MAX:     cfg.light_max_code   <= cfg_data;
        CFG_SOIL_MIN:      cfg.soil_min_code    <= cfg_data;
        CFG_SOIL_MAX:      cfg.soil_max_code    <= cfg_data;
        CFG_SENSOR_HEIGHT: cfg.sensor_height_mm <= cfg_data[HEIGHT_W-1:0];
        CFG_FULL_HEIGHT:   cfg.full_height_mm   <= cfg_data[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // Front: takes one request at a time, drops channels out of range,
  // converts ADC code or echo time to percent in 1/256 steps.
  spma_front #(
    .CHANNEL_COUNT (CHANNEL_COUNT)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .push   (push),
    .full   (full),
    .sample (sample),
    .q_push (q_push),
    .q_item (q_wr_item),
    .q_full (q_full)
  );

  // Short queue so the front can convert the next request while the back
  // is still averaging or its result waits to be popped.
  spma_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_item (q_wr_item),
    .full    (q_full),
    .pop     (q_pop),
    .rd_item (q_rd_item),
    .empty   (q_empty)
  );

  // Back: ring store in RAM, running sum, invalid count and rounded mean;
  // holds the result register that drives the output queue side.
  spma_back #(
    .WINDOW_DEPTH  (WINDOW_DEPTH),
    .CHANNEL_COUNT (CHANNEL_COUNT)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .q_item  (q_rd_item),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

endmodule

// ===== hdl/spma_checker.sv =====
// Port-level checker for the top level and its bind statement.
`include "assert_macros.svh"

module spma_checker import spma_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    push,
  input logic    full,
  input sample_t sample,
  input logic    empty,
  input logic    pop,
  input result_t result
);

  `SPMA_ASSERT_IMPL(a_invalid_level_zero, clk, rst, !empty && !result.level_valid, result.level == '0)
  `SPMA_ASSERT_IMPL(a_level_in_range, clk, rst, !empty, result.level <= LEVEL_W'(FULL_SCALE))
  `SPMA_ASSERT_NEXT(a_result_held, clk, rst, !empty && !pop, !empty && $stable(result))
  `SPMA_ASSERT_NEXT(a_busy_after_accept, clk, rst, push && !full && sample.func == CH_SOIL, full)
  `SPMA_ASSERT_NEXT_ALWAYS(a_reset_empties, clk, rst, empty)

endmodule

bind sensor_percent_moving_average_top spma_checker u_spma_checker (
  .clk    (clk),
  .rst    (rst),
  .push   (push),
  .full   (full),
  .sample (sample),
  .empty  (empty),
  .pop    (pop),
  .result (result)
);

// ===== tb/tb.sv =====
// Self-checking testbench for the sensor percent moving average block.
module tb;
  import spma_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WINDOW   = 8;
  localparam int CHANNELS = 3;

  // func code that maps to no channel: the block drops the request silently
  localparam logic [FUNC_W-1:0] CH_UNUSED = 2'd3;

  localparam int NUM_SETTINGS     = 9;     // reset values plus eight written sets
  localparam int ITEMS_PER_PHASE  = 192;   // random requests per setting, dropped ones excluded
  localparam int SETTLE_CYCLES    = 100;   // covers the longest latency of one request
  localparam int LONG_HOLD_AT     = 300;   // result count at which the consumer stops
  localparam int LONG_HOLD_CYCLES = 500;
  localparam int EAGER_TOGGLE     = 150;   // results between changes of the consumer's mode

  localparam bit TYPED     = 1'b1;
  localparam bit PREDICTED = 1'b0;

  // One directed request. When typed is set, level and valid hold the
  // result worked out by hand; otherwise the predictor supplies it.
  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [RAW_W-1:0]   raw;
    bit                 typed;
    logic [LEVEL_W-1:0] level;
    bit                 valid;
  } probe_row_t;

  localparam int NUM_PROBES = 24;

  // Walk runs against the reset register values: soil 150..3600,
  // light 300..3600, sensor 200 mm, full 180 mm.
  localparam probe_row_t PROBE_ROWS [NUM_PROBES] = '{
    '{CH_SOIL,   13'd150,  TYPED,     15'd25600, 1'b1},  // at min code: full scale
    '{CH_SOIL,   13'd3600, TYPED,     15'd12800, 1'b1},  // at max code: zero, mean of two
    '{CH_SOIL,   13'd0,    TYPED,     15'd0,     1'b0},  // invalid sample poisons window
    '{CH_LIGHT,  13'd8191, TYPED,     15'd0,     1'b1},  // all-ones code, clamped to 0 %
    '{CH_LIGHT,  13'd1,    TYPED,     15'd12800, 1'b1},  // below min: 100 %
    '{CH_WATER,  13'd1,    TYPED,     15'd25600, 1'b1},  // shortest echo: clamped full
    '{CH_WATER,  13'd8191, TYPED,     15'd12800, 1'b1},  // longest echo: height negative
    '{CH_UNUSED, 13'd4660, PREDICTED, 15'd0,     1'b0},  // dropped, no result
    '{CH_WATER,  13'd0,    TYPED,     15'd0,     1'b0},  // invalid echo
    '{CH_SOIL,   13'd149,  PREDICTED, 15'd0,     1'b0},
    '{CH_SOIL,   13'd3601, PREDICTED, 15'd0,     1'b0},
    '{CH_SOIL,   13'd1875, PREDICTED, 15'd0,     1'b0},
    '{CH_SOIL,   13'd4095, PREDICTED, 15'd0,     1'b0},
    '{CH_SOIL,   13'd2048, PREDICTED, 15'd0,     1'b0},
    '{CH_SOIL,   13'd1,    PREDICTED, 15'd0,     1'b0},  // window already full: wraps over the first slot
    '{CH_SOIL,   13'd150,  PREDICTED, 15'd0,     1'b0},  // wraps over the second slot
    '{CH_SOIL,   13'd1000, PREDICTED, 15'd0,     1'b0},
    '{CH_SOIL,   13'd2000, PREDICTED, 15'd0,     1'b0},  // invalid slot already evicted
    '{CH_LIGHT,  13'd300,  PREDICTED, 15'd0,     1'b0},
    '{CH_LIGHT,  13'd3600, PREDICTED, 15'd0,     1'b0},
    '{CH_WATER,  13'd1176, PREDICTED, 15'd0,     1'b0},  // height just above zero
    '{CH_WATER,  13'd1177, PREDICTED, 15'd0,     1'b0},  // height just below zero
    '{CH_WATER,  13'd118,  PREDICTED, 15'd0,     1'b0},  // just under full scale
    '{CH_UNUSED, 13'd8191, PREDICTED, 15'd0,     1'b0}
  };

  // DUT ports; every input is known from time zero
  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   push = 1'b0;
  logic                   full;
  sample_t                sample = '0;
  logic                   empty;
  logic                   pop = 1'b0;
  result_t                result;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // predictor state: register copy and one ring per channel
  cfg_t               cfg_shadow;
  logic [LEVEL_W-1:0] ring_level [CHANNELS][WINDOW];
  bit                 ring_ok    [CHANNELS][WINDOW];
  int unsigned        ring_pos   [CHANNELS];
  int unsigned        ring_fill  [CHANNELS];
  int unsigned        level_sum  [CHANNELS];
  int unsigned        bad_count  [CHANNELS];

  result_t level_expect [$];   // filtered levels still owed by the block

  // bookkeeping
  int unsigned fails = 0;
  int unsigned requests_sent = 0;
  int unsigned requests_dropped = 0;
  int unsigned levels_checked = 0;
  int unsigned levels_flagged = 0;
  bit          calm_sender = 1'b0;

  // consumer state
  int unsigned pop_hold = 0;
  int unsigned eager_left = 0;
  bit          eager = 1'b0;
  bit          long_hold_done = 1'b0;
  int          stall_pick;

  sensor_percent_moving_average_top #(
    .WINDOW_DEPTH (WINDOW),
    .CHANNEL_COUNT(CHANNELS)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .sample   (sample),
    .empty    (empty),
    .pop      (pop),
    .result   (result),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // 2 ns clock
  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // ADC code to percent: min code reads 100 %, max code 0 %.
  // Signed span, so min above max inverts the map; equal codes snap.
  function automatic logic [LEVEL_W-1:0] code_to_percent(input logic [RAW_W-1:0] code,
                                                         input logic [CODE_W-1:0] lo,
                                                         input logic [CODE_W-1:0] hi);
    longint num;
    longint den;
    longint ratio;
    num = code;
    num = num - longint'(lo);
    den = hi;
    den = den - longint'(lo);
    if (den == 0) begin
      ratio = (num > 0) ? FULL_SCALE : 0;
    end else if (((num < 0) != (den < 0)) || num == 0) begin
      ratio = 0;
    end else begin
      if (num < 0) num = -num;
      if (den < 0) den = -den;
      ratio = (num * FULL_SCALE) / den;
      if (ratio > FULL_SCALE) ratio = FULL_SCALE;
    end
    return LEVEL_W'(FULL_SCALE - ratio);
  endfunction

  // Echo time to fill percent. 0.17 mm/us is exact as 17/100, so work in 1/100 mm.
  function automatic logic [LEVEL_W-1:0] echo_to_percent(input logic [RAW_W-1:0] echo,
                                                         input logic [HEIGHT_W-1:0] height,
                                                         input logic [HEIGHT_W-1:0] full_h);
    longint e;
    longint h;
    longint f;
    longint water;
    longint pct;
    e = echo;
    h = height;
    f = full_h;
    water = 100 * h - 17 * e;
    if (water <= 0) return '0;
    if (f == 0) return LEVEL_W'(FULL_SCALE);
    pct = (water * 256) / f;
    if (pct > FULL_SCALE) pct = FULL_SCALE;
    return LEVEL_W'(pct);
  endfunction

  // Push one request through the predictor. Returns 0 when the block drops it.
  function automatic bit average_sample(input sample_t s, output result_t r);
    int unsigned        ch;
    int unsigned        pos;
    int unsigned        n;
    int unsigned        mean;
    logic [LEVEL_W-1:0] pct;
    bit                 good;
    ch   = s.func;
    good = (s.raw_sample != '0);
    pct  = '0;
    r    = '0;
    if (ch >= CHANNELS) return 1'b0;
    if (good) begin
      case (s.func)
        CH_SOIL:  pct = code_to_percent(s.raw_sample, cfg_shadow.soil_min_code,
                                        cfg_shadow.soil_max_code);
        CH_LIGHT: pct = code_to_percent(s.raw_sample, cfg_shadow.light_min_code,
                                        cfg_shadow.light_max_code);
        default:  pct = echo_to_percent(s.raw_sample, cfg_shadow.sensor_height_mm,
                                        cfg_shadow.full_height_mm);
      endcase
    end
    // replace the oldest slot, keep sum and invalid count running
    pos = ring_pos[ch];
    level_sum[ch] = level_sum[ch] - ring_level[ch][pos];
    if (!ring_ok[ch][pos]) bad_count[ch] = bad_count[ch] - 1;
    ring_level[ch][pos] = pct;
    ring_ok[ch][pos]    = good;
    level_sum[ch] = level_sum[ch] + pct;
    if (!good) bad_count[ch] = bad_count[ch] + 1;
    ring_pos[ch] = (pos + 1) % WINDOW;
    if (ring_fill[ch] < WINDOW) ring_fill[ch] = ring_fill[ch] + 1;
    // round half up over the filled slots
    n = ring_fill[ch];
    mean = (level_sum[ch] + n / 2) / n;
    r.channel = s.func;
    if (bad_count[ch] == 0) begin
      r.level       = LEVEL_W'(mean);
      r.level_valid = 1'b1;
    end
    return 1'b1;
  endfunction

  // Random request: mostly in-range codes and echoes, some near the
  // calibration points, some full-width noise, a few invalid or unmapped.
  function automatic sample_t make_random_sample();
    sample_t s;
    int      pick;
    int      lo;
    int      hi;
    int      anchor;
    pick = $urandom_range(0, 99);
    s.func = (pick < 8) ? CH_UNUSED : FUNC_W'($urandom_range(0, CHANNELS - 1));
    case (s.func)
      CH_SOIL: begin
        lo = int'(cfg_shadow.soil_min_code);
        hi = int'(cfg_shadow.soil_max_code);
      end
      CH_LIGHT: begin
        lo = int'(cfg_shadow.light_min_code);
        hi = int'(cfg_shadow.light_max_code);
      end
      default: begin
        // echoes at which the water reads full and empty
        lo = (100 * (int'(cfg_shadow.sensor_height_mm) - int'(cfg_shadow.full_height_mm))) / 17;
        if (lo < 0) lo = 0;
        hi = (100 * int'(cfg_shadow.sensor_height_mm)) / 17;
      end
    endcase
    pick = $urandom_range(0, 99);
    if (pick < 6) begin
      s.raw_sample = '0;
    end else if (pick < 16) begin
      s.raw_sample = RAW_W'($urandom_range(0, 8191));
    end else if (pick < 30) begin
      anchor = ($urandom_range(0, 1) != 0) ? lo : hi;
      anchor = anchor + int'($urandom_range(0, 6)) - 3;
      if (anchor < 0) anchor = 0;
      if (anchor > 8191) anchor = 8191;
      s.raw_sample = RAW_W'(anchor);
    end else if (s.func == CH_WATER) begin
      s.raw_sample = RAW_W'($urandom_range(1, (hi + 16 > 8191) ? 8191 : hi + 16));
    end else begin
      s.raw_sample = RAW_W'($urandom_range(0, 4095));
    end
    return s;
  endfunction

  // Offer one request and hold it until the block takes it.
  task automatic send_sample(input sample_t s, input bit typed, input result_t typed_r);
    result_t predicted;
    bit      owes;
    push   <= 1'b1;
    sample <= s;
    @(posedge clk);
    while (full) @(posedge clk);
    owes = average_sample(s, predicted);
    if (owes) begin
      level_expect.push_back(typed ? typed_r : predicted);
    end else begin
      requests_dropped++;
    end
    requests_sent++;
  endtask

  // Producer gap: mostly none, sometimes short, now and then long.
  task automatic pause();
    int pick;
    int gap;
    pick = $urandom_range(0, 99);
    gap  = 0;
    if (!calm_sender) begin
      if (pick >= 92) gap = $urandom_range(6, 40);
      else if (pick >= 65) gap = $urandom_range(1, 3);
    end
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      CFG_LIGHT_MIN:     cfg_shadow.light_min_code   = val;
      CFG_LIGHT_MAX:     cfg_shadow.light_max_code   = val;
      CFG_SOIL_MIN:      cfg_shadow.soil_min_code    = val;
      CFG_SOIL_MAX:      cfg_shadow.soil_max_code    = val;
      CFG_SENSOR_HEIGHT: cfg_shadow.sensor_height_mm = val[HEIGHT_W-1:0];
      CFG_FULL_HEIGHT:   cfg_shadow.full_height_mm   = val[HEIGHT_W-1:0];
      default: ;
    endcase
  endtask

  // Full set of registers, written in index order.
  task automatic write_settings(input logic [CFG_DATA_W-1:0] light_lo,
                                input logic [CFG_DATA_W-1:0] light_hi,
                                input logic [CFG_DATA_W-1:0] soil_lo,
                                input logic [CFG_DATA_W-1:0] soil_hi,
                                input logic [CFG_DATA_W-1:0] height,
                                input logic [CFG_DATA_W-1:0] full_h);
    write_reg(CFG_LIGHT_MIN, light_lo);
    write_reg(CFG_LIGHT_MAX, light_hi);
    write_reg(CFG_SOIL_MIN, soil_lo);
    write_reg(CFG_SOIL_MAX, soil_hi);
    write_reg(CFG_SENSOR_HEIGHT, height);
    write_reg(CFG_FULL_HEIGHT, full_h);
    cfg_write <= 1'b0;
  endtask

  // Compare one popped result with the oldest owed level.
  task automatic check_level(input result_t got);
    result_t want;
    if (level_expect.size() == 0) begin
      fails++;
      $display("%0t: result with nothing owed: channel %0d level %0d valid %0b",
               $time, got.channel, got.level, got.level_valid);
    end else begin
      want = level_expect.pop_front();
      if (got.channel !== want.channel) begin
        fails++;
        $display("%0t: channel mismatch, expected %0d, got %0d",
                 $time, want.channel, got.channel);
      end
      if (got.level !== want.level) begin
        fails++;
        $display("%0t: level mismatch on channel %0d, expected %0d, got %0d",
                 $time, want.channel, want.level, got.level);
      end
      if (got.level_valid !== want.level_valid) begin
        fails++;
        $display("%0t: level_valid mismatch on channel %0d, expected %0b, got %0b",
                 $time, want.channel, want.level_valid, got.level_valid);
      end
      if (!want.level_valid) levels_flagged++;
    end
    levels_checked++;
  endtask

  // Consumer: checks each popped result, then decides pop for the next edge.
  // It alternates between an eager mode and random stalls, and once holds
  // off for a long stretch so the block backs up and raises full.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        check_level(result);
        if (eager_left == 0) begin
          eager      = !eager;
          eager_left = EAGER_TOGGLE;
        end else begin
          eager_left--;
        end
      end
      if (levels_checked == LONG_HOLD_AT && !long_hold_done) begin
        long_hold_done = 1'b1;
        pop_hold       = LONG_HOLD_CYCLES;
      end
      if (pop_hold != 0) begin
        pop_hold--;
        pop <= 1'b0;
      end else if (eager) begin
        pop <= 1'b1;
      end else begin
        stall_pick = $urandom_range(0, 99);
        if (stall_pick < 70) begin
          pop <= 1'b1;
        end else begin
          pop <= 1'b0;
          pop_hold = (stall_pick < 95) ? $urandom_range(0, 2) : $urandom_range(7, 30);
        end
      end
    end
  end

  // Hard stop in case the block hangs.
  initial begin
    #2000000;
    $display("%0t: timeout with %0d results still owed", $time, level_expect.size());
    $display("== FAIL ==");
    $finish;
  end

  // Stimulus: directed walk, then random requests under a series of settings.
  initial begin
    result_t     hand_level;
    sample_t     s;
    int unsigned count;

    cfg_shadow.light_min_code   = RST_LIGHT_MIN;
    cfg_shadow.light_max_code   = RST_LIGHT_MAX;
    cfg_shadow.soil_min_code    = RST_SOIL_MIN;
    cfg_shadow.soil_max_code    = RST_SOIL_MAX;
    cfg_shadow.sensor_height_mm = RST_SENSOR_HEIGHT;
    cfg_shadow.full_height_mm   = RST_FULL_HEIGHT;
    for (int c = 0; c < CHANNELS; c++) begin
      for (int k = 0; k < WINDOW; k++) begin
        ring_level[c][k] = '0;
        ring_ok[c][k]    = 1'b1;   // unwritten slots count as valid zeros
      end
      ring_pos[c]  = 0;
      ring_fill[c] = 0;
      level_sum[c] = 0;
      bad_count[c] = 0;
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed walk under reset register values
    for (int i = 0; i < NUM_PROBES; i++) begin
      s.func                  = PROBE_ROWS[i].func;
      s.raw_sample            = PROBE_ROWS[i].raw;
      hand_level.channel      = PROBE_ROWS[i].func;
      hand_level.level        = PROBE_ROWS[i].level;
      hand_level.level_valid  = PROBE_ROWS[i].valid;
      send_sample(s, PROBE_ROWS[i].typed, hand_level);
      pause();
    end

    for (int phase = 0; phase < NUM_SETTINGS; phase++) begin
      if (phase != 0) begin
        // registers change only with the block idle: drain, then let any
        // dropped request work its way out
        push <= 1'b0;
        while (level_expect.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        case (phase)
          1: write_settings(12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0);
          // inverted light map, equal soil codes, zero full height
          2: write_settings(12'd4095, 12'd0, 12'd2000, 12'd2000, 12'd1023, 12'd0);
          // widest light span, equal top codes, height writes with spare bits set
          3: write_settings(12'd0, 12'd4095, 12'd4095, 12'd4095, 12'hFFF, 12'hFFF);
          // smallest nonzero heights, inverted light map
          4: write_settings(12'd3000, 12'd1000, 12'd1, 12'd4094, 12'd1, 12'd1);
          default: write_settings(CFG_DATA_W'($urandom_range(0, 4095)),
                                  CFG_DATA_W'($urandom_range(0, 4095)),
                                  CFG_DATA_W'($urandom_range(0, 4095)),
                                  CFG_DATA_W'($urandom_range(0, 4095)),
                                  CFG_DATA_W'($urandom_range(0, 4095)),
                                  CFG_DATA_W'($urandom_range(0, 4095)));
        endcase
      end
      // every third setting runs the producer back to back
      calm_sender = (phase % 3 == 1);
      count = 0;
      while (count < ITEMS_PER_PHASE) begin
        s = make_random_sample();
        send_sample(s, PREDICTED, '0);
        if (s.func != CH_UNUSED) count++;
        pause();
      end
    end

    push <= 1'b0;
    while (level_expect.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d requests over %0d register settings, %0d dropped as unmapped.",
             requests_sent, NUM_SETTINGS, requests_dropped);
    $display("Checked %0d filtered levels, %0d of them flagged invalid.",
             levels_checked, levels_flagged);
    if (fails == 0 && level_expect.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
